FILE: sv/mpcs_pkg.sv
// package for the multilevel priority scheduler
// shared constants and types; no dependencies
package mpcs_pkg;
  localparam int TableEntries = 32;
  localparam int IdxW = $clog2(TableEntries);
  localparam logic [15:0] QuantumReset = 16'd20;
  localparam logic signed [7:0] AgeStep = 8'sd10;
  localparam logic signed [7:0] AgeLimit = 8'sd30;
  localparam logic signed [7:0] AgeCap = 8'sd31;

  // one table entry as it travels along the chain
  typedef struct packed {
    logic        valid;
    logic [15:0] pid;
    logic signed [7:0] prio;
    logic [15:0] total;
    logic [15:0] remaining;
    logic [31:0] arrival;
    logic [31:0] order;
  } entry_t;

  // best candidate travelling with the scan
  typedef struct packed {
    logic            found;
    logic [IdxW-1:0] idx;
    logic            rt;
    logic signed [7:0] prio;
    logic [31:0]     age;
  } cand_t;

  // control from the sequencer to the cells
  typedef struct packed {
    logic            shift;
    logic            load;
    logic            kill;
    logic            update;
    entry_t          data;
  } cell_ctl_t;

  function automatic logic [2:0] queue_of(input logic signed [7:0] p);
    if (p < 0) return 3'd0;
    else if (p >= 1 && p <= 10) return 3'd1;
    else if (p <= 20) return 3'd2;
    else if (p <= AgeLimit) return 3'd3;
    else return 3'd4;
  endfunction
endpackage

FILE: sv/mpcs_cell.sv
// one table slot of the scheduler chain
// depends on mpcs_pkg
module mpcs_cell import mpcs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  logic      sel,
  input  entry_t    prev,
  output entry_t    cur
);
  // shift along the ring, or write / clear when selected
  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
    end else if (ctl.shift) begin
      cur <= prev;
    end else if (sel && ctl.kill) begin
      cur.valid <= 1'b0;
    end else if (sel && (ctl.load || ctl.update)) begin
      cur <= ctl.data;
    end
  end
endmodule

FILE: sv/multilevel_priority_cpu_scheduler_unit.sv
// top level of the multilevel priority scheduler
// depends on mpcs_pkg and mpcs_cell
// Every transaction, arrival or tick, keeps busy high through S_SCAN and S_ACT:
// the table is a ring of cells that rotates once per transaction so a single
// compare stage sees each slot in turn, then S_ACT acts on the ring at its home
// position. A result, if any, is on done for one cycle right after busy falls,
// with no back-pressure: the receiver must take every one. Write the quantum
// only while busy is low.
module multilevel_priority_cpu_scheduler_unit import mpcs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        kind,
  input  logic [15:0] proc_pid,
  input  logic signed [7:0] arrival_priority,
  input  logic [15:0] compute_time,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  output logic        done,
  output logic        status,
  output logic [15:0] done_pid,
  output logic [2:0]  queue_label,
  output logic signed [7:0] final_priority,
  output logic [15:0] total_compute,
  output logic signed [31:0] turnaround
);
  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_ACT} state_t;
  state_t state;
  logic [15:0] quantum;
  logic [31:0] now_time, arr_clock, order_counter;
  logic        op_kind;
  entry_t      in_e;
  logic [IdxW:0] cnt;
  cand_t       best;
  logic [IdxW-1:0] free_idx;
  logic        free_found;
  cell_ctl_t   ctl;
  entry_t      cells [TableEntries];
  logic [IdxW-1:0] pos;
  entry_t      head;
  entry_t      sel_e;

  // ring of cells, last feeds first
  for (genvar i = 0; i < TableEntries; i++) begin : g_cell
    mpcs_cell u_cell (
      .clk(clk), .rst(rst), .ctl(ctl),
      .sel(pos == IdxW'(i)),
      .prev(cells[(i + TableEntries - 1) % TableEntries]),
      .cur(cells[i]));
  end
  assign head = cells[TableEntries-1];
  assign sel_e = cells[best.idx];

  // candidate compare on the slot leaving the ring head
  logic [IdxW-1:0] head_idx;
  logic [31:0] head_age;
  logic head_rt, take;
  assign head_idx = IdxW'(cnt);
  assign head_age = order_counter - head.order;
  assign head_rt = head.prio < 0;
  always_comb begin
    take = 1'b0;
    if (head.valid) begin
      if (!best.found) take = 1'b1;
      else if (head_rt != best.rt) take = head_rt;
      else if (head_rt) take = head_age > best.age;
      else take = head.prio < best.prio ||
                  (head.prio == best.prio && head_age > best.age);
    end
  end

  // aging and service arithmetic for the chosen slot
  logic [15:0] rem;
  logic finish;
  logic signed [8:0] aged;
  entry_t upd;
  assign rem = sel_e.remaining;
  assign finish = {16'd0, rem} <= {16'd0, quantum};
  assign aged = 9'(sel_e.prio) + 9'(AgeStep);
  always_comb begin
    upd = sel_e;
    upd.remaining = rem - quantum;
    upd.order = order_counter;
    if (sel_e.prio >= 0) upd.prio = (aged > 9'(AgeLimit)) ? AgeCap : aged[7:0];
  end

  // cell control: rotate while scanning, then act at home position
  always_comb begin
    ctl = '0;
    ctl.shift = (state == S_SCAN);
    pos = '0;
    if (state == S_ACT) begin
      if (!op_kind) begin
        ctl.load = free_found;
        pos = free_idx;
        ctl.data = in_e;
        ctl.data.arrival = arr_clock;
        ctl.data.order = order_counter;
      end else begin
        pos = best.idx;
        ctl.kill = best.found && quantum != 0 && finish;
        ctl.update = best.found && quantum != 0 && !finish;
        ctl.data = upd;
      end
    end
  end

  assign busy = (state != S_IDLE);

  // sequencer, counters and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; quantum <= QuantumReset; now_time <= '0;
      arr_clock <= '0; order_counter <= '0; done <= 1'b0;
      cnt <= '0; best <= '0; free_found <= 1'b0; free_idx <= '0;
    end else begin
      done <= (state == S_ACT) &&
              (op_kind ? (best.found && quantum != 0 && finish) : !free_found);
      if (cfg_we && state == S_IDLE) quantum <= cfg_data;
      unique case (state)
        S_IDLE: if (start) begin
          op_kind <= kind;
          in_e.valid <= 1'b1; in_e.pid <= proc_pid;
          in_e.prio <= arrival_priority; in_e.total <= compute_time;
          in_e.remaining <= compute_time; in_e.arrival <= '0; in_e.order <= '0;
          cnt <= (IdxW+1)'(TableEntries - 1);
          best <= '0; free_found <= 1'b0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (take) begin
            best.found <= 1'b1; best.idx <= head_idx; best.rt <= head_rt;
            best.prio <= head.prio; best.age <= head_age;
          end
          if (!head.valid) begin
            free_found <= 1'b1; free_idx <= head_idx;
          end
          if (cnt == '0) state <= S_ACT;
          else cnt <= cnt - 1'b1;
        end
        S_ACT: begin
          state <= S_IDLE;
          if (!op_kind) begin
            if (free_found) order_counter <= order_counter + 1'b1;
            else begin
              status <= 1'b1; done_pid <= in_e.pid;
              queue_label <= 3'd0; final_priority <= in_e.prio;
              total_compute <= in_e.total; turnaround <= '0;
            end
          end else begin
            arr_clock <= arr_clock + 32'(quantum);
            if (best.found && quantum != 0) begin
              if (finish) begin
                now_time <= now_time + 32'(rem);
                status <= 1'b0; done_pid <= sel_e.pid;
                queue_label <= queue_of(sel_e.prio);
                final_priority <= sel_e.prio; total_compute <= sel_e.total;
                turnaround <= now_time + 32'(rem) - sel_e.arrival;
              end else begin
                now_time <= now_time + 32'(quantum);
                order_counter <= order_counter + 1'b1;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
